@@ design/mrrc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and the CRC-16 byte update for the Modbus RTU
// response checker. No dependencies.
package mrrc_pkg;

  localparam int unsigned CountW = 9;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;
  localparam logic [7:0]  ExceptionFlag = 8'h80;
  localparam logic [CountW-1:0] ExceptionLen = CountW'(5);
  localparam logic [CountW-1:0] EchoLen = CountW'(8);
  localparam logic [CountW-1:0] ReadOverhead = CountW'(5);
  localparam logic [6:0] FuncWriteSingle = 7'd6;
  localparam logic [6:0] FuncWriteMultiple = 7'd16;

  typedef enum logic [1:0] {
    OpArm        = 2'd0,
    OpByte       = 2'd1,
    OpTimeout    = 2'd2,
    OpDisconnect = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    StatusOk           = 3'd0,
    StatusTimeout      = 3'd1,
    StatusMalformed    = 3'd2,
    StatusCrc          = 3'd3,
    StatusException    = 3'd4,
    StatusEchoMismatch = 3'd5,
    StatusCountMismatch = 3'd6,
    StatusDisconnected = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    CfgStationAddr    = 2'd0,
    CfgFunctionCode   = 2'd1,
    CfgExpectedFirst  = 2'd2,
    CfgExpectedSecond = 2'd3
  } cfg_index_e;

  typedef struct packed {
    logic [7:0]  station_addr;
    logic [6:0]  function_code;
    logic [15:0] expected_first;
    logic [15:0] expected_second;
  } cfg_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] register_word;
    logic        is_final;
    logic [2:0]  status;
    logic [7:0]  exception_code;
  } result_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] crc;
    crc = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      crc = crc[0] ? ((crc >> 1) ^ CrcPoly) : (crc >> 1);
    end
    return crc;
  endfunction

  function automatic result_t make_final(input status_e st, input logic [7:0] code);
    result_t r;
    r.valid = 1'b1;
    r.register_word = 16'h0000;
    r.is_final = 1'b1;
    r.status = st;
    r.exception_code = code;
    return r;
  endfunction

endpackage

@@ design/modbus_rtu_response_checker_top.sv @@
`timescale 1ns / 1ps
// Modbus RTU response checker: input register, frame core and result register.
// Depends on mrrc_pkg and mrrc_core.
//
// The checker takes one event item per clock (arm, received byte, wait expired
// or disconnect) and returns at most one result item for it: a big-endian read
// register word, or the closing status of the response. An accepted item is
// held in the input register, processed combinationally by the frame core
// (address and function hunt, length tracking, one CRC-16 byte update and the
// final checks) and captured in the result register once the output is free.
// The sustained rate is one item per cycle; the input stalls only while a
// result waits on a stalled output. The user must write the configuration
// registers only while no response is in flight; the block does not enforce it.
module modbus_rtu_response_checker_top #(
  parameter int unsigned MAX_FRAME = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] register_word_o,
  output logic        is_final_o,
  output logic [2:0]  status_o,
  output logic [7:0]  exception_code_o
);

  mrrc_pkg::cfg_t    cfg_q;
  mrrc_pkg::item_t   item_q;
  logic              in_valid_q;
  mrrc_pkg::result_t res;
  logic              out_valid_q;
  logic [15:0]       word_q;
  logic              final_q;
  logic [2:0]        status_q;
  logic [7:0]        code_q;
  logic              out_free;
  logic              step;

  assign out_free = !out_valid_q || !out_stall_i;
  assign step = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.station_addr <= 8'd1;
      cfg_q.function_code <= 7'd3;
      cfg_q.expected_first <= 16'd0;
      cfg_q.expected_second <= 16'd1;
    end else if (cfg_we_i) begin
      case (mrrc_pkg::cfg_index_e'(cfg_index_i))
        mrrc_pkg::CfgStationAddr:    cfg_q.station_addr <= cfg_data_i[7:0];
        mrrc_pkg::CfgFunctionCode:   cfg_q.function_code <= cfg_data_i[6:0];
        mrrc_pkg::CfgExpectedFirst:  cfg_q.expected_first <= cfg_data_i;
        mrrc_pkg::CfgExpectedSecond: cfg_q.expected_second <= cfg_data_i;
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      item_q.operation <= operation_i;
      item_q.data_byte <= data_byte_i;
    end
  end

  mrrc_core #(
    .MAX_FRAME(MAX_FRAME)
  ) u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(step),
    .item_i(item_q),
    .cfg_i (cfg_q),
    .res_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step && res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && step && res.valid) begin
      word_q <= res.register_word;
      final_q <= res.is_final;
      status_q <= res.status;
      code_q <= res.exception_code;
    end
  end

  assign out_valid_o = out_valid_q;
  assign register_word_o = word_q;
  assign is_final_o = final_q;
  assign status_o = status_q;
  assign exception_code_o = code_q;

endmodule

@@ design/mrrc_core.sv @@
`timescale 1ns / 1ps
// Frame state and combinational byte processing of the response checker.
// Depends on mrrc_pkg.
module mrrc_core #(
  parameter int unsigned MAX_FRAME = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  mrrc_pkg::item_t  item_i,
  input  mrrc_pkg::cfg_t   cfg_i,
  output mrrc_pkg::result_t res_o
);

  localparam int unsigned CountW = mrrc_pkg::CountW;
  localparam logic [CountW-1:0] MaxFrameC = CountW'(MAX_FRAME);

  logic [CountW-1:0] count_q, count_d;
  logic [CountW-1:0] flen_q, flen_d;
  logic [15:0]       crc_q, crc_d;
  logic [15:0]       tail_q, tail_d;
  logic              exc_q, exc_d;
  logic [7:0]        pay_q, pay_d;
  logic [7:0]        held_q, held_d;
  logic [31:0]       echo_q, echo_d;
  logic              fin_q, fin_d;

  logic [7:0]  b;
  logic        is_write;
  logic        fc_match;
  logic        addr_match;
  logic [15:0] crc_base;
  logic [15:0] crc_new;
  logic        overlong;

  assign b = item_i.data_byte;
  assign is_write = (cfg_i.function_code == mrrc_pkg::FuncWriteSingle) ||
                    (cfg_i.function_code == mrrc_pkg::FuncWriteMultiple);
  assign fc_match = (b == {1'b0, cfg_i.function_code}) ||
                    (b == ({1'b0, cfg_i.function_code} | mrrc_pkg::ExceptionFlag));
  assign addr_match = (b == cfg_i.station_addr);
  assign crc_base = ((count_q == '0) || ((count_q == CountW'(1)) && !fc_match)) ?
                    mrrc_pkg::CrcInit : crc_q;
  assign crc_new = mrrc_pkg::crc_byte(crc_base, b);

  always_comb begin
    count_d = count_q;
    flen_d = flen_q;
    crc_d = crc_q;
    tail_d = tail_q;
    exc_d = exc_q;
    pay_d = pay_q;
    held_d = held_q;
    echo_d = echo_q;
    fin_d = fin_q;
    overlong = 1'b0;
    res_o = '0;
    if (step_i) begin
      case (mrrc_pkg::op_e'(item_i.operation))
        mrrc_pkg::OpArm: begin
          count_d = '0;
          flen_d = '0;
          crc_d = mrrc_pkg::CrcInit;
          tail_d = '0;
          exc_d = 1'b0;
          pay_d = '0;
          held_d = '0;
          echo_d = '0;
          fin_d = 1'b0;
        end
        mrrc_pkg::OpByte: begin
          if (!fin_q) begin
            if (count_q == '0) begin
              if (addr_match) begin
                crc_d = crc_new;
                count_d = CountW'(1);
              end
            end else if (count_q == CountW'(1)) begin
              if (fc_match) begin
                exc_d = b[7];
                crc_d = crc_new;
                count_d = CountW'(2);
                if (is_write) begin
                  flen_d = b[7] ? mrrc_pkg::ExceptionLen : mrrc_pkg::EchoLen;
                end
              end else if (addr_match) begin
                crc_d = crc_new;
                count_d = CountW'(1);
              end else begin
                crc_d = mrrc_pkg::CrcInit;
                count_d = '0;
              end
            end else begin
              if ((flen_q != '0) && ((count_q + CountW'(2)) >= flen_q)) begin
                tail_d = {b, tail_q[15:8]};
              end else begin
                crc_d = crc_new;
              end
              count_d = count_q + CountW'(1);
              if (count_q == CountW'(2)) begin
                pay_d = b;
                if (!is_write) begin
                  flen_d = exc_q ? mrrc_pkg::ExceptionLen :
                           (CountW'(b) + mrrc_pkg::ReadOverhead);
                  overlong = (flen_d > MaxFrameC);
                end
              end
              if (is_write && !exc_q && (count_q >= CountW'(2)) && (count_q <= CountW'(5))) begin
                echo_d = {echo_q[23:0], b};
              end
              if (overlong) begin
                res_o = mrrc_pkg::make_final(mrrc_pkg::StatusMalformed, 8'h00);
                fin_d = 1'b1;
              end else if (!is_write && !exc_q && (count_q >= CountW'(3)) &&
                           (count_q < (CountW'(pay_d) + CountW'(3)))) begin
                if (count_q[0]) begin
                  held_d = b;
                end else begin
                  res_o.valid = 1'b1;
                  res_o.register_word = {held_q, b};
                end
              end else if ((flen_d != '0) && (count_d == flen_d)) begin
                fin_d = 1'b1;
                if (tail_d != crc_d) begin
                  res_o = mrrc_pkg::make_final(mrrc_pkg::StatusCrc, 8'h00);
                end else if (exc_q) begin
                  res_o = mrrc_pkg::make_final(mrrc_pkg::StatusException, pay_d);
                end else if (is_write) begin
                  if ((echo_d[31:16] != cfg_i.expected_first) ||
                      (echo_d[15:0] != cfg_i.expected_second)) begin
                    res_o = mrrc_pkg::make_final(mrrc_pkg::StatusEchoMismatch, 8'h00);
                  end else begin
                    res_o = mrrc_pkg::make_final(mrrc_pkg::StatusOk, 8'h00);
                  end
                end else if (pay_d[0] || ({9'h000, pay_d[7:1]} != cfg_i.expected_second)) begin
                  res_o = mrrc_pkg::make_final(mrrc_pkg::StatusCountMismatch, 8'h00);
                end else begin
                  res_o = mrrc_pkg::make_final(mrrc_pkg::StatusOk, 8'h00);
                end
              end
            end
          end
        end
        mrrc_pkg::OpTimeout: begin
          if (!fin_q) begin
            res_o = mrrc_pkg::make_final((count_q == '0) ? mrrc_pkg::StatusTimeout :
                                         mrrc_pkg::StatusMalformed, 8'h00);
            fin_d = 1'b1;
          end
        end
        mrrc_pkg::OpDisconnect: begin
          if (!fin_q) begin
            res_o = mrrc_pkg::make_final(mrrc_pkg::StatusDisconnected, 8'h00);
            fin_d = 1'b1;
          end
        end
        default: begin
          fin_d = fin_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      flen_q <= '0;
      crc_q <= mrrc_pkg::CrcInit;
      tail_q <= '0;
      exc_q <= 1'b0;
      pay_q <= '0;
      held_q <= '0;
      echo_q <= '0;
      fin_q <= 1'b1;
    end else begin
      count_q <= count_d;
      flen_q <= flen_d;
      crc_q <= crc_d;
      tail_q <= tail_d;
      exc_q <= exc_d;
      pay_q <= pay_d;
      held_q <= held_d;
      echo_q <= echo_d;
      fin_q <= fin_d;
    end
  end

`ifndef SYNTHESIS
  a_count_within_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (flen_q != '0) |-> (count_q <= flen_q))
    else $error("Received count runs past the frame length.");

  a_length_unknown_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q < CountW'(2)) |-> (flen_q == '0))
    else $error("Frame length known before the function code.");

  a_final_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && res_o.valid && res_o.is_final) |=> fin_q)
    else $error("Closing status did not end the response.");

  a_idle_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && fin_q && (item_i.operation != mrrc_pkg::OpArm)) |=> fin_q)
    else $error("Idle checker left idle without an arm.");

  a_word_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.is_final) |->
      ((res_o.status == mrrc_pkg::StatusOk) && (res_o.exception_code == 8'h00)))
    else $error("Word item carries a status.");
`endif

endmodule

@@ tb/sv/modbus_rtu_response_checker_top_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for modbus_rtu_response_checker_top: directed frames, then random
// responses under several settings, checked against a behavioral response predictor.
// Depends on mrrc_pkg and the checker RTL.
module modbus_rtu_response_checker_top_tb;

  localparam int unsigned MaxFrame = 256;
  localparam int unsigned QuietLimit = 3000;
  localparam int unsigned PrintLimit = 40;

  typedef enum logic [1:0] {
    StallNone,
    StallRandom,
    StallPattern,
    StallBursts
  } stall_style_e;

  typedef struct packed {
    logic [15:0] word;
    logic        closing;
    logic [2:0]  status;
    logic [7:0]  exc_code;
  } reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = mrrc_pkg::CfgStationAddr;
  logic [15:0] cfg_data_i = 16'h0000;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  operation_i = mrrc_pkg::OpArm;
  logic [7:0]  data_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] register_word_o;
  logic        is_final_o;
  logic [2:0]  status_o;
  logic [7:0]  exception_code_o;

  // Settings and frame state as the predictor sees them.
  logic [7:0]  cfg_addr = 8'd1;
  logic [6:0]  cfg_func = 7'd3;
  logic [15:0] cfg_first = 16'd0;
  logic [15:0] cfg_second = 16'd1;
  logic [8:0]  rx_count = '0;
  logic [8:0]  frame_len = '0;
  logic [15:0] crc_acc = mrrc_pkg::CrcInit;
  logic [15:0] crc_tail = '0;
  logic        exc_frame = 1'b0;
  logic [7:0]  count_byte = '0;
  logic [7:0]  high_byte = '0;
  logic [31:0] echo_bytes = '0;
  logic        response_done = 1'b1;

  reply_t      reply_q[$];
  logic [7:0]  frame_bytes[$];
  int unsigned error_count = 0;
  int unsigned events_taken = 0;
  int unsigned quiet_cycles = 0;
  int unsigned stall_tick = 0;
  int unsigned stall_run = 0;
  logic        stall_level = 1'b0;
  stall_style_e stall_style = StallNone;
  int unsigned gap_max = 0;
  int unsigned burst_left = 0;

  modbus_rtu_response_checker_top #(
    .MAX_FRAME(MaxFrame)
  ) DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .operation_i(operation_i),
    .data_byte_i(data_byte_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .register_word_o(register_word_o),
    .is_final_o(is_final_o),
    .status_o(status_o),
    .exception_code_o(exception_code_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic logic [15:0] crc16_step(logic [15:0] acc, logic [7:0] value);
    logic [15:0] r;
    r = acc ^ {8'h00, value};
    repeat (8) r = r[0] ? ({1'b0, r[15:1]} ^ mrrc_pkg::CrcPoly) : {1'b0, r[15:1]};
    return r;
  endfunction

  function automatic logic is_write_func();
    return cfg_func == mrrc_pkg::FuncWriteSingle || cfg_func == mrrc_pkg::FuncWriteMultiple;
  endfunction

  task automatic push_status(mrrc_pkg::status_e st, logic [7:0] code);
    reply_t r;
    r.word = 16'h0000;
    r.closing = 1'b1;
    r.status = st;
    r.exc_code = code;
    reply_q.push_back(r);
    response_done = 1'b1;
  endtask

  task automatic push_word(logic [15:0] word);
    reply_t r;
    r.word = word;
    r.closing = 1'b0;
    r.status = mrrc_pkg::StatusOk;
    r.exc_code = 8'h00;
    reply_q.push_back(r);
  endtask

  task automatic take_response_byte(logic [7:0] b);
    logic [8:0] pos;
    logic       wr;
    pos = rx_count;
    wr = is_write_func();
    if (pos == 9'd0) begin
      if (b == cfg_addr) begin
        crc_acc = crc16_step(mrrc_pkg::CrcInit, b);
        rx_count = 9'd1;
      end
      return;
    end
    if (pos == 9'd1) begin
      if (b == {1'b0, cfg_func} || b == {1'b1, cfg_func}) begin
        exc_frame = b[7];
        crc_acc = crc16_step(crc_acc, b);
        rx_count = 9'd2;
        if (wr) frame_len = exc_frame ? mrrc_pkg::ExceptionLen : mrrc_pkg::EchoLen;
      end else if (b == cfg_addr) begin
        crc_acc = crc16_step(mrrc_pkg::CrcInit, b);
        rx_count = 9'd1;
      end else begin
        crc_acc = mrrc_pkg::CrcInit;
        rx_count = 9'd0;
      end
      return;
    end
    if (frame_len != 9'd0 && pos + 9'd2 >= frame_len) crc_tail = {b, crc_tail[15:8]};
    else crc_acc = crc16_step(crc_acc, b);
    rx_count = pos + 9'd1;
    if (pos == 9'd2) begin
      count_byte = b;
      if (!wr) begin
        frame_len = exc_frame ? mrrc_pkg::ExceptionLen : 9'(b) + mrrc_pkg::ReadOverhead;
        if (frame_len > MaxFrame) begin
          push_status(mrrc_pkg::StatusMalformed, 8'h00);
          return;
        end
      end
    end
    if (wr && !exc_frame && pos >= 9'd2 && pos <= 9'd5) echo_bytes = {echo_bytes[23:0], b};
    if (!wr && !exc_frame && pos >= 9'd3 && pos < 9'(count_byte) + 9'd3) begin
      if (pos[0]) begin
        high_byte = b;
      end else begin
        push_word({high_byte, b});
        return;
      end
    end
    if (frame_len != 9'd0 && rx_count == frame_len) begin
      if (crc_tail != crc_acc) push_status(mrrc_pkg::StatusCrc, 8'h00);
      else if (exc_frame) push_status(mrrc_pkg::StatusException, count_byte);
      else if (wr) begin
        if (echo_bytes[31:16] != cfg_first || echo_bytes[15:0] != cfg_second)
          push_status(mrrc_pkg::StatusEchoMismatch, 8'h00);
        else push_status(mrrc_pkg::StatusOk, 8'h00);
      end else if (count_byte[0] || 16'(count_byte[7:1]) != cfg_second) begin
        push_status(mrrc_pkg::StatusCountMismatch, 8'h00);
      end else begin
        push_status(mrrc_pkg::StatusOk, 8'h00);
      end
    end
  endtask

  task automatic predict_response(mrrc_pkg::op_e op, logic [7:0] b);
    if (op == mrrc_pkg::OpArm) begin
      rx_count = '0;
      frame_len = '0;
      crc_acc = mrrc_pkg::CrcInit;
      crc_tail = '0;
      exc_frame = 1'b0;
      count_byte = '0;
      high_byte = '0;
      echo_bytes = '0;
      response_done = 1'b0;
      events_taken++;
      return;
    end
    if (response_done) return;
    events_taken++;
    case (op)
      mrrc_pkg::OpByte: take_response_byte(b);
      mrrc_pkg::OpTimeout:
        push_status(rx_count == 9'd0 ? mrrc_pkg::StatusTimeout : mrrc_pkg::StatusMalformed,
                    8'h00);
      default: push_status(mrrc_pkg::StatusDisconnected, 8'h00);
    endcase
  endtask

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    if (error_count < PrintLimit)
      $display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    error_count++;
  endtask

  task automatic check_reply();
    reply_t want;
    if (reply_q.size() == 0) begin
      report_mismatch("unexpected item", register_word_o, 16'h0000);
      return;
    end
    want = reply_q.pop_front();
    if (register_word_o !== want.word) report_mismatch("register_word", register_word_o, want.word);
    if (is_final_o !== want.closing) report_mismatch("is_final", 16'(is_final_o), 16'(want.closing));
    if (status_o !== want.status) report_mismatch("status", 16'(status_o), 16'(want.status));
    if (exception_code_o !== want.exc_code)
      report_mismatch("exception_code", 16'(exception_code_o), 16'(want.exc_code));
  endtask

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (out_valid_o && !out_stall_i) check_reply();
    stall_tick++;
    case (stall_style)
      StallNone: out_stall_i <= 1'b0;
      StallRandom: out_stall_i <= ($urandom_range(2) == 0);
      StallPattern: out_stall_i <= ((stall_tick % 7) < 3);
      default: begin
        if (stall_run == 0) begin
          stall_run = $urandom_range(14, 1);
          stall_level = ~stall_level;
        end
        stall_run--;
        out_stall_i <= stall_level;
      end
    endcase
  end

  task automatic send_event(mrrc_pkg::op_e op, logic [7:0] value);
    if (gap_max != 0 && burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(gap_max, 1)) @(posedge clk_i);
      burst_left = $urandom_range(12, 1);
    end
    if (burst_left != 0) burst_left--;
    in_valid_i <= 1'b1;
    operation_i <= op;
    data_byte_i <= value;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_response(op, value);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apply_settings(logic [7:0] addr, logic [6:0] func, logic [15:0] first,
                                logic [15:0] second);
    mrrc_pkg::cfg_index_e order[4] = '{mrrc_pkg::CfgStationAddr, mrrc_pkg::CfgFunctionCode,
                                       mrrc_pkg::CfgExpectedFirst,
                                       mrrc_pkg::CfgExpectedSecond};
    logic [15:0] values[4];
    values = '{{8'h00, addr}, {9'h000, func}, first, second};
    for (int k = 0; k < 4; k++) begin
      cfg_we_i <= 1'b1;
      cfg_index_i <= order[k];
      cfg_data_i <= values[k];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    cfg_addr = addr;
    cfg_func = func;
    cfg_first = first;
    cfg_second = second;
  endtask

  task automatic seal_frame();
    logic [15:0] c;
    c = mrrc_pkg::CrcInit;
    foreach (frame_bytes[k]) c = crc16_step(c, frame_bytes[k]);
    frame_bytes.push_back(c[7:0]);
    frame_bytes.push_back(c[15:8]);
  endtask

  task automatic send_frame_bytes(int unsigned keep);
    for (int unsigned k = 0; k < keep; k++) send_event(mrrc_pkg::OpByte, frame_bytes[k]);
  endtask

  task automatic send_random_response();
    logic [7:0]  count;
    int unsigned pick;
    int unsigned keep;
    send_event(mrrc_pkg::OpArm, 8'($urandom));
    pick = $urandom_range(99);
    if (pick < 8) begin
      repeat ($urandom_range(6, 1))
        send_event(mrrc_pkg::op_e'($urandom_range(3)), 8'($urandom));
      return;
    end
    if (pick < 18) repeat ($urandom_range(3, 1)) send_event(mrrc_pkg::OpByte, 8'($urandom));
    frame_bytes.delete();
    frame_bytes.push_back($urandom_range(19) == 0 ? 8'($urandom) : cfg_addr);
    pick = $urandom_range(99);
    if (pick < 70) frame_bytes.push_back({1'b0, cfg_func});
    else if (pick < 88) frame_bytes.push_back({1'b1, cfg_func});
    else frame_bytes.push_back(8'($urandom));
    if (frame_bytes[1][7]) begin
      frame_bytes.push_back(8'($urandom));
    end else if (is_write_func()) begin
      frame_bytes.push_back(cfg_first[15:8]);
      frame_bytes.push_back(cfg_first[7:0]);
      frame_bytes.push_back(cfg_second[15:8]);
      frame_bytes.push_back(cfg_second[7:0]);
      if ($urandom_range(4) == 0)
        frame_bytes[2 + $urandom_range(3)] ^= 8'(1 << $urandom_range(7));
    end else begin
      pick = $urandom_range(99);
      if (pick < 60 && cfg_second < 16'd10) count = 8'(cfg_second * 2);
      else if (pick < 90) count = 8'($urandom_range(9));
      else count = 8'($urandom_range(40));
      frame_bytes.push_back(count);
      repeat (count) frame_bytes.push_back(8'($urandom));
    end
    seal_frame();
    if ($urandom_range(7) == 0)
      frame_bytes[$urandom_range(frame_bytes.size() - 1)] ^= 8'(1 << $urandom_range(7));
    keep = frame_bytes.size();
    pick = $urandom_range(99);
    if (pick < 12) keep = $urandom_range(frame_bytes.size() - 1);
    send_frame_bytes(keep);
    // A cut frame left without a closing event is dropped by the next arm.
    if (pick < 6) send_event(mrrc_pkg::OpTimeout, 8'($urandom));
    else if (pick < 9) send_event(mrrc_pkg::OpDisconnect, 8'($urandom));
    else if (pick >= 90) send_event(mrrc_pkg::op_e'($urandom_range(3, 1)), 8'($urandom));
  endtask

  task automatic test_idle_events();
    stall_style = StallRandom;
    gap_max = 3;
    send_event(mrrc_pkg::OpByte, 8'h01);
    send_event(mrrc_pkg::OpTimeout, 8'hFF);
    send_event(mrrc_pkg::OpDisconnect, 8'h00);
    send_event(mrrc_pkg::OpArm, 8'h00);
    send_event(mrrc_pkg::OpTimeout, 8'h00);
    send_event(mrrc_pkg::OpArm, 8'hFF);
    send_event(mrrc_pkg::OpByte, 8'h01);
    send_event(mrrc_pkg::OpTimeout, 8'h00);
  endtask

  task automatic test_resync_and_disconnect();
    send_event(mrrc_pkg::OpArm, 8'h00);
    send_event(mrrc_pkg::OpByte, 8'h01);
    send_event(mrrc_pkg::OpByte, 8'h01);
    send_event(mrrc_pkg::OpByte, 8'h55);
    send_event(mrrc_pkg::OpByte, 8'h01);
    send_event(mrrc_pkg::OpDisconnect, 8'h00);
  endtask

  task automatic test_overlong_and_rearm();
    send_event(mrrc_pkg::OpArm, 8'h00);
    send_event(mrrc_pkg::OpByte, 8'h01);
    send_event(mrrc_pkg::OpByte, 8'h03);
    send_event(mrrc_pkg::OpByte, 8'hFF);
    send_event(mrrc_pkg::OpByte, 8'h00);
    send_event(mrrc_pkg::OpArm, 8'h00);
    send_event(mrrc_pkg::OpByte, 8'h01);
    send_event(mrrc_pkg::OpByte, 8'h03);
    send_event(mrrc_pkg::OpArm, 8'h00);
    frame_bytes = '{8'h01, 8'h83, 8'h02};
    seal_frame();
    send_frame_bytes(frame_bytes.size());
    send_event(mrrc_pkg::OpArm, 8'h00);
    frame_bytes = '{8'h01, 8'h03, 8'h02, 8'hAB, 8'hCD};
    seal_frame();
    send_frame_bytes(frame_bytes.size());
  endtask

  task automatic test_frame_limit();
    stall_style = StallPattern;
    gap_max = 0;
    send_event(mrrc_pkg::OpArm, 8'h00);
    frame_bytes = '{8'h01, 8'h03, 8'd251};
    repeat (251) frame_bytes.push_back(8'($urandom));
    seal_frame();
    send_frame_bytes(frame_bytes.size());
    send_event(mrrc_pkg::OpArm, 8'h00);
    send_event(mrrc_pkg::OpByte, 8'h01);
    send_event(mrrc_pkg::OpByte, 8'h03);
    send_event(mrrc_pkg::OpByte, 8'd252);
    send_event(mrrc_pkg::OpByte, 8'h00);
  endtask

  task automatic run_phase(logic [7:0] addr, logic [6:0] func, logic [15:0] first,
                           logic [15:0] second, int unsigned gaps, stall_style_e style);
    int unsigned goal;
    drain();
    apply_settings(addr, func, first, second);
    gap_max = gaps;
    stall_style = style;
    goal = events_taken + 80;
    while (events_taken < goal) send_random_response();
  endtask

  task automatic test_random_traffic();
    run_phase(8'd1, 7'd3, 16'd0, 16'd2, 4, StallRandom);
    run_phase(8'd0, 7'd0, 16'h0000, 16'h0000, 0, StallNone);
    run_phase(8'd255, 7'd127, 16'hFFFF, 16'hFFFF, 2, StallBursts);
    run_phase(8'($urandom), mrrc_pkg::FuncWriteSingle, 16'($urandom), 16'($urandom), 5,
              StallPattern);
    run_phase(8'($urandom), mrrc_pkg::FuncWriteMultiple, 16'($urandom),
              16'($urandom_range(9)), 3, StallBursts);
    run_phase(8'($urandom), 7'd4, 16'($urandom), 16'($urandom_range(6)), 6, StallRandom);
  endtask

  initial begin
    while (quiet_cycles < QuietLimit) @(posedge clk_i);
    $display("modbus_rtu_response_checker_top verification failed");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_events();
    test_resync_and_disconnect();
    test_overlong_and_rearm();
    test_frame_limit();
    test_random_traffic();
    drain();
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("modbus_rtu_response_checker_top verification clean");
    end else begin
      $display("modbus_rtu_response_checker_top verification failed");
    end
    $finish;
  end

endmodule
